### hdl/gspoll_pkg.sv
// ----------------------------------------------------------------------------
// gspoll_pkg
// Shared types, frame tables and key decode constants for the gamepad
// serial poll sequencer.
// ----------------------------------------------------------------------------
package gspoll_pkg;

  typedef enum logic [2:0] {
    PH_ENTER  = 3'd0,
    PH_ANALOG = 3'd1,
    PH_EXIT   = 3'd2,
    PH_IDCHK  = 3'd3,
    PH_POLL   = 3'd4
  } phase_t;

  localparam logic [7:0] ANALOG_ID_RESET = 8'h73;

  // frame byte positions that carry the id and report data
  localparam logic [3:0] POS_ID      = 4'd1;
  localparam logic [3:0] POS_BTN_1ST = 4'd3;
  localparam logic [3:0] POS_BTN_2ND = 4'd4;
  localparam logic [3:0] POS_STICK_X = 4'd7;

  // first button byte patterns (active low)
  localparam logic [7:0] BTN_START = 8'hF7;
  localparam logic [7:0] BTN_UP    = 8'hEF;
  localparam logic [7:0] BTN_LEFT  = 8'h7F;
  localparam logic [7:0] BTN_RIGHT = 8'hDF;
  localparam logic [7:0] BTN_DOWN  = 8'h9F;

  // second button byte patterns (active low)
  localparam logic [7:0] BTN_L2     = 8'hFE;
  localparam logic [7:0] BTN_R2     = 8'hFD;
  localparam logic [7:0] BTN_L1     = 8'hFB;
  localparam logic [7:0] BTN_R1     = 8'hF7;
  localparam logic [7:0] BTN_A      = 8'hEF;
  localparam logic [7:0] BTN_CIRCLE = 8'hDF;
  localparam logic [7:0] BTN_CROSS  = 8'hBF;
  localparam logic [7:0] BTN_SQUARE = 8'h7F;

  localparam logic [2:0] K1_NONE  = 3'd0;
  localparam logic [2:0] K1_START = 3'd1;
  localparam logic [2:0] K1_UP    = 3'd2;
  localparam logic [2:0] K1_LEFT  = 3'd3;
  localparam logic [2:0] K1_RIGHT = 3'd4;
  localparam logic [2:0] K1_DOWN  = 3'd5;

  localparam logic [3:0] K2_NONE   = 4'd0;
  localparam logic [3:0] K2_L2     = 4'd1;
  localparam logic [3:0] K2_R2     = 4'd2;
  localparam logic [3:0] K2_L1     = 4'd3;
  localparam logic [3:0] K2_R1     = 4'd4;
  localparam logic [3:0] K2_A      = 4'd5;
  localparam logic [3:0] K2_CIRCLE = 4'd6;
  localparam logic [3:0] K2_CROSS  = 4'd7;
  localparam logic [3:0] K2_SQUARE = 4'd8;

  typedef struct packed {
    logic [7:0] buttons_first;
    logic [7:0] buttons_second;
    logic [7:0] stick_x;
    logic [7:0] stick_y;
    logic [2:0] first_key_code;
    logic [3:0] second_key_code;
    logic [3:0] stick_flags;
  } report_t;

  // index of the last byte of a frame; unused codes act as enter config
  function automatic logic [3:0] frame_last(phase_t ph);
    logic [3:0] r;
    case (ph)
      PH_ANALOG, PH_EXIT, PH_IDCHK, PH_POLL: r = 4'd8;
      default:  r = 4'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] frame_cmd(phase_t ph, logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos == 4'd0) begin
      c = 8'h01;
    end else begin
      case (ph)
        PH_ANALOG: begin
          case (pos)
            4'd1:    c = 8'h44;
            4'd3:    c = 8'h01;
            4'd4:    c = 8'h03;
            default: c = 8'h00;
          endcase
        end
        PH_EXIT: begin
          case (pos)
            4'd1:    c = 8'h43;
            4'd4, 4'd5, 4'd6, 4'd7, 4'd8: c = 8'h5A;
            default: c = 8'h00;
          endcase
        end
        PH_IDCHK, PH_POLL: begin
          case (pos)
            4'd1:    c = 8'h42;
            default: c = 8'h00;
          endcase
        end
        default: begin
          case (pos)
            4'd1:    c = 8'h43;
            4'd3:    c = 8'h01;
            default: c = 8'h00;
          endcase
        end
      endcase
    end
    return c;
  endfunction

endpackage

### hdl/gspoll_ifs.sv
// ----------------------------------------------------------------------------
// gspoll channel interfaces
// Valid/ready channels for response bytes, command results and the
// analog id register write.
// ----------------------------------------------------------------------------
interface gspoll_resp_if;
  logic       valid;
  logic       ready;
  logic [7:0] resp_byte;
  modport source (output valid, output resp_byte, input ready);
  modport sink   (input valid, input resp_byte, output ready);
endinterface

interface gspoll_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] next_cmd;
  logic       frame_done;
  logic       report_valid;
  logic [7:0] buttons_first;
  logic [7:0] buttons_second;
  logic [7:0] stick_x;
  logic [7:0] stick_y;
  logic [2:0] first_key_code;
  logic [3:0] second_key_code;
  logic [3:0] stick_flags;
  logic       in_analog_mode;
  modport source (
    output valid, output next_cmd, output frame_done, output report_valid,
    output buttons_first, output buttons_second, output stick_x, output stick_y,
    output first_key_code, output second_key_code, output stick_flags,
    output in_analog_mode, input ready
  );
  modport sink (
    input valid, input next_cmd, input frame_done, input report_valid,
    input buttons_first, input buttons_second, input stick_x, input stick_y,
    input first_key_code, input second_key_code, input stick_flags,
    input in_analog_mode, output ready
  );
endinterface

interface gspoll_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] analog_id;
  modport source (output valid, output analog_id, input ready);
  modport sink   (input valid, input analog_id, output ready);
endinterface

### hdl/gspoll_report_decode.sv
// ----------------------------------------------------------------------------
// gspoll_report_decode
// Builds the poll report: key codes from exact button patterns and stick
// extreme flags; all fields zero when no report is due.
// ----------------------------------------------------------------------------
module gspoll_report_decode import gspoll_pkg::*; (
  input  logic       en,
  input  logic [7:0] btn_first,
  input  logic [7:0] btn_second,
  input  logic [7:0] stick_x,
  input  logic [7:0] stick_y,
  output report_t    report
);

  logic [2:0] k1;
  logic [3:0] k2;

  always_comb begin
    case (btn_first)
      BTN_START: k1 = K1_START;
      BTN_UP:    k1 = K1_UP;
      BTN_LEFT:  k1 = K1_LEFT;
      BTN_RIGHT: k1 = K1_RIGHT;
      BTN_DOWN:  k1 = K1_DOWN;
      default:   k1 = K1_NONE;
    endcase
  end

  always_comb begin
    case (btn_second)
      BTN_L2:     k2 = K2_L2;
      BTN_R2:     k2 = K2_R2;
      BTN_L1:     k2 = K2_L1;
      BTN_R1:     k2 = K2_R1;
      BTN_A:      k2 = K2_A;
      BTN_CIRCLE: k2 = K2_CIRCLE;
      BTN_CROSS:  k2 = K2_CROSS;
      BTN_SQUARE: k2 = K2_SQUARE;
      default:    k2 = K2_NONE;
    endcase
  end

  always_comb begin
    report = '0;
    if (en) begin
      report.buttons_first   = btn_first;
      report.buttons_second  = btn_second;
      report.stick_x         = stick_x;
      report.stick_y         = stick_y;
      report.first_key_code  = k1;
      report.second_key_code = k2;
      report.stick_flags     = {stick_y == 8'hFF, stick_y == 8'h00,
                                stick_x == 8'hFF, stick_x == 8'h00};
    end
  end

endmodule

### hdl/gamepad_serial_poll_sequencer_top.sv
// ----------------------------------------------------------------------------
// gamepad_serial_poll_sequencer_top
// Byte-level host sequencer: config frames until analog id matches, then
// 9-byte polls with decoded report.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  resp     in   resp_byte
//  cmd      out  next_cmd, frame_done, report fields, in_analog_mode
//  cfg      in   analog_id write
//
//  one request per cycle; the result is registered and shows in the
//  cycle after acceptance. frame state and decode sit between the
//  accepted byte and the result register. resp is taken while the result
//  register is empty or being drained, so a stalled cmd side holds one
//  result and stops further requests. sync reset returns to the enter
//  config frame and sets analog_id to 0x73; cfg is always ready.
module gamepad_serial_poll_sequencer_top import gspoll_pkg::*; (
  input  logic clk,
  input  logic rst,
  gspoll_resp_if.sink  resp,
  gspoll_cmd_if.source cmd,
  gspoll_cfg_if.sink   cfg
);

  logic [7:0] analog_id;
  phase_t     phase, phase_next;
  logic [3:0] byte_pos, byte_pos_next;
  logic [7:0] id_seen, id_seen_next;
  logic [7:0] held_btn_first, held_btn_first_next;
  logic [7:0] held_btn_second, held_btn_second_next;
  logic [7:0] held_stick_x, held_stick_x_next;

  logic       out_valid;
  logic       take;
  logic       is_last;
  logic       report_en;
  report_t    report;
  report_t    report_q;
  logic [7:0] cmd_q;
  logic       frame_done_q;
  logic       report_valid_q;
  logic       analog_q;

  assign resp.ready = !out_valid || cmd.ready;
  assign take       = resp.valid && resp.ready;
  assign cfg.ready  = 1'b1;

  always_comb begin
    id_seen_next         = id_seen;
    held_btn_first_next  = held_btn_first;
    held_btn_second_next = held_btn_second;
    held_stick_x_next    = held_stick_x;
    phase_next           = phase;
    report_en            = 1'b0;
    is_last              = byte_pos >= frame_last(phase);

    if (phase == PH_IDCHK && byte_pos == POS_ID) begin
      id_seen_next = resp.resp_byte;
    end
    if (phase == PH_POLL) begin
      if (byte_pos == POS_BTN_1ST) begin
        held_btn_first_next = resp.resp_byte;
      end else if (byte_pos == POS_BTN_2ND) begin
        held_btn_second_next = resp.resp_byte;
      end else if (byte_pos == POS_STICK_X) begin
        held_stick_x_next = resp.resp_byte;
      end
    end

    if (is_last) begin
      byte_pos_next = 4'd0;
      case (phase)
        PH_POLL:   report_en = 1'b1;
        PH_IDCHK:  phase_next = (id_seen == analog_id) ? PH_POLL : PH_ENTER;
        PH_ENTER:  phase_next = PH_ANALOG;
        PH_ANALOG: phase_next = PH_EXIT;
        PH_EXIT:   phase_next = PH_IDCHK;
        default:   phase_next = PH_ANALOG;
      endcase
    end else begin
      byte_pos_next = byte_pos + 4'd1;
    end
  end

  gspoll_report_decode u_decode (
    .en         (report_en),
    .btn_first  (held_btn_first),
    .btn_second (held_btn_second),
    .stick_x    (held_stick_x),
    .stick_y    (resp.resp_byte),
    .report     (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      analog_id <= ANALOG_ID_RESET;
    end else if (cfg.valid) begin
      analog_id <= cfg.analog_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_ENTER;
      byte_pos        <= 4'd0;
      id_seen         <= 8'd0;
      held_btn_first  <= 8'd0;
      held_btn_second <= 8'd0;
      held_stick_x    <= 8'd0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        phase           <= phase_next;
        byte_pos        <= byte_pos_next;
        id_seen         <= id_seen_next;
        held_btn_first  <= held_btn_first_next;
        held_btn_second <= held_btn_second_next;
        held_stick_x    <= held_stick_x_next;
        out_valid       <= 1'b1;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q          <= frame_cmd(phase_next, byte_pos_next);
      frame_done_q   <= is_last;
      report_valid_q <= report_en;
      report_q       <= report;
      analog_q       <= (phase_next == PH_POLL);
    end
  end

  assign cmd.valid           = out_valid;
  assign cmd.next_cmd        = cmd_q;
  assign cmd.frame_done      = frame_done_q;
  assign cmd.report_valid    = report_valid_q;
  assign cmd.buttons_first   = report_q.buttons_first;
  assign cmd.buttons_second  = report_q.buttons_second;
  assign cmd.stick_x         = report_q.stick_x;
  assign cmd.stick_y         = report_q.stick_y;
  assign cmd.first_key_code  = report_q.first_key_code;
  assign cmd.second_key_code = report_q.second_key_code;
  assign cmd.stick_flags     = report_q.stick_flags;
  assign cmd.in_analog_mode  = analog_q;

endmodule
